[hdl/assert_macros.svh]
// Assertion macros shared by the string unescape RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_CLK(lbl, clk, rst, !(cond), msg)

`endif

[hdl/sle_pkg.sv]
// Shared types, constants and decode functions for the string unescape block.
// No dependencies; imported by every module of the block.
package sle_pkg;

   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   localparam logic [7:0] CharBslash = 8'h5C;
   localparam logic [7:0] CharDquote = 8'h22;
   localparam logic [7:0] CharApos   = 8'h27;
   localparam logic [7:0] CharLowX   = 8'h78;
   localparam logic [7:0] CharUpX    = 8'h58;

   typedef enum logic [2:0] {
      MODE_PLAIN  = 3'd0,
      MODE_BSLASH = 3'd1,
      MODE_HEX1   = 3'd2,
      MODE_HEX2   = 3'd3,
      MODE_OCT2   = 3'd4,
      MODE_OCT3   = 3'd5
   } mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       err;
      logic       last;
   } entry_type;

   // Results produced by one accepted byte, slot e0 first.
   typedef struct packed {
      logic [1:0] cnt;
      entry_type  e0;
      entry_type  e1;
   } push_type;

   function automatic entry_type mk_entry(input logic [7:0] data, input logic has_byte,
                                          input logic err);
      entry_type e;
      e.data     = data;
      e.has_byte = has_byte;
      e.err      = err;
      e.last     = 1'b0;
      return e;
   endfunction

   // {bad, value}: bad set when the byte is not a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      if (b >= 8'h30 && b <= 8'h39)      r = {1'b0, b[3:0]};
      else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b[3:0] + 4'd9)};
      else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b[3:0] + 4'd9)};
      else                               r = 5'b1_0000;
      return r;
   endfunction

   // {ok, value} for single-character escapes.
   function automatic logic [8:0] simple_escape(input logic [7:0] b);
      logic [8:0] r;
      case (b)
         8'h61:   r = {1'b1, 8'h07};
         8'h62:   r = {1'b1, 8'h08};
         8'h65:   r = {1'b1, 8'h1B};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         8'h76:   r = {1'b1, 8'h0B};
         CharDquote, CharApos, CharBslash: r = {1'b1, b};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

[hdl/sle_front.sv]
// Front end: accepts literal bytes, runs the escape state machine, pushes results.
// Depends on sle_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sle_front import sle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_accept,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output push_type   push
);

   mode_type   mode_ff, mode_in;
   logic [7:0] pval_ff, pval_in;
   logic       perr_ff, perr_in;
   logic [1:0] n;
   entry_type  r0, r1, e;
   logic [4:0] hx;
   logic [8:0] esc;
   logic       do_plain;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         pval_ff <= '0;
         perr_ff <= 1'b0;
      end else if (in_accept) begin
         mode_ff <= mode_in;
         pval_ff <= pval_in;
         perr_ff <= perr_in;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      pval_in  = pval_ff;
      perr_in  = perr_ff;
      n        = 2'd0;
      r0       = '0;
      r1       = '0;
      e        = '0;
      do_plain = 1'b0;
      hx       = hex_digit(in_byte);
      esc      = simple_escape(in_byte);

      unique case (mode_ff)
         MODE_BSLASH: begin
            if (in_byte == CharLowX || in_byte == CharUpX) begin
               pval_in = '0;
               perr_in = 1'b0;
               mode_in = MODE_HEX1;
            end else if (in_byte[7:2] == 6'b001100) begin
               pval_in = {6'd0, in_byte[1:0]};
               perr_in = 1'b0;
               mode_in = MODE_OCT2;
            end else if (esc[8]) begin
               e       = mk_entry(esc[7:0], 1'b1, 1'b0);
               mode_in = MODE_PLAIN;
            end else begin
               // unknown escape: flag it, escape stays open
               e = mk_entry(8'd0, 1'b0, 1'b1);
            end
            if (!(in_byte == CharLowX || in_byte == CharUpX || in_byte[7:2] == 6'b001100)) begin
               r0 = e;
               n  = 2'd1;
            end
         end
         MODE_HEX1: begin
            if (hx[4]) perr_in = 1'b1;
            pval_in = {hx[4] ? 4'd0 : hx[3:0], 4'd0};
            mode_in = MODE_HEX2;
         end
         MODE_HEX2: begin
            pval_in = pval_ff | {4'd0, hx[4] ? 4'd0 : hx[3:0]};
            r0      = mk_entry(pval_in, 1'b1, perr_ff | hx[4]);
            n       = 2'd1;
            perr_in = 1'b0;
            mode_in = MODE_PLAIN;
         end
         MODE_OCT2, MODE_OCT3: begin
            if (in_byte[7:3] == 5'b00110) begin
               pval_in = {pval_ff[4:0], in_byte[2:0]};
               if (mode_ff == MODE_OCT2) begin
                  mode_in = MODE_OCT3;
               end else begin
                  r0      = mk_entry(pval_in, 1'b1, 1'b0);
                  n       = 2'd1;
                  mode_in = MODE_PLAIN;
               end
            end else begin
               // octal ended early: flush value, then treat byte as plain
               r0       = mk_entry(pval_ff, 1'b1, 1'b0);
               n        = 2'd1;
               do_plain = 1'b1;
            end
         end
         default: do_plain = 1'b1;
      endcase

      if (do_plain) begin
         if (in_byte == CharBslash) begin
            mode_in = MODE_BSLASH;
         end else begin
            e       = mk_entry(in_byte, 1'b1, 1'b0);
            mode_in = MODE_PLAIN;
            if (n == 2'd0) r0 = e;
            else           r1 = e;
            n = n + 2'd1;
         end
      end

      if (in_last) begin
         if (mode_in == MODE_OCT2 || mode_in == MODE_OCT3) begin
            e = mk_entry(pval_in, 1'b1, 1'b0);
         end else if (mode_in != MODE_PLAIN) begin
            e = mk_entry(8'd0, 1'b0, 1'b1);
         end else begin
            e = mk_entry(8'd0, 1'b0, 1'b0);
         end
         if (mode_in != MODE_PLAIN || n == 2'd0) begin
            if (n == 2'd0) r0 = e;
            else           r1 = e;
            n = n + 2'd1;
         end
         if (n == 2'd1) r0.last = 1'b1;
         else           r1.last = 1'b1;
         mode_in = MODE_PLAIN;
         pval_in = '0;
         perr_in = 1'b0;
      end

      push.cnt = in_accept ? n : 2'd0;
      push.e0  = r0;
      push.e1  = r1;
   end

   `ASSERT_CLK(a_last_to_plain, clock, reset, in_accept && in_last |=> mode_ff == MODE_PLAIN,
      "mode not plain after last byte")
   `ASSERT_NEVER(a_last_has_result, clock, reset, in_accept && in_last && push.cnt == 2'd0,
      "last byte produced no result")

endmodule

[hdl/sle_queue.sv]
// Short result queue between front and back: up to two writes, one read per cycle.
// Depends on sle_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sle_queue import sle_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      space,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);

   entry_type        mem_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;
   logic             do_pop;

   assign empty  = (count_ff == '0);
   assign space  = (count_ff <= QCntW'(QDepth - 2));
   assign head   = mem_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPtrW'(push.cnt);
      rd_ptr_in = rd_ptr_ff + QPtrW'(do_pop);
      count_in  = count_ff + QCntW'(push.cnt) - QCntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) mem_ff[wr_ptr_ff] <= push.e0;
      if (push.cnt == 2'd2) mem_ff[QPtrW'(wr_ptr_ff + 1'b1)] <= push.e1;
   end

   `ASSERT_NEVER(a_q_overflow, clock, reset, count_ff > QCntW'(QDepth), "queue overflow")
   `ASSERT_NEVER(a_q_push_full, clock, reset, push.cnt != 2'd0 && !space,
      "push without room for two entries")

endmodule

[hdl/sle_back.sv]
// Back end: moves queued results into the output register and drives the rsp stream.
// Depends on sle_pkg.
module sle_back import sle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  entry_type  q_head,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [1:0] rsp_tuser,
   output logic       rsp_tlast
);

   logic      valid_ff, valid_in;
   entry_type out_ff;

   assign q_pop    = !q_empty && (!valid_ff || rsp_tready);
   assign valid_in = q_pop || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) out_ff <= q_head;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = out_ff.data;
   assign rsp_tuser  = {out_ff.err, out_ff.has_byte};
   assign rsp_tlast  = out_ff.last;

endmodule

[hdl/string_literal_unescape.sv]
// Top level of the string literal unescape block: front, result queue, back.
// Depends on sle_pkg, sle_front, sle_queue and sle_back.
//
//  channel | dir | payload
//  --------+-----+-------------------------------------------------------
//  req_*   | in  | tdata: literal byte; tlast: final byte of the literal
//  rsp_*   | out | tdata: decoded byte; tuser: has_byte, escape_error;
//          |     | tlast: final result of a literal
//
// One input byte is taken per cycle while req_tready is high; it gives zero, one
// or two results, which leave at one per cycle from the output register while
// rsp_tready is high; each result passes the queue, then the output register.
// req_tready drops while the four-entry result queue has fewer than two free slots.
// Reset is synchronous; it empties the queue and returns the decoder to plain mode.
module string_literal_unescape import sle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] has_byte, [1] escape_error
   output logic       rsp_tlast
);

   push_type  push;
   entry_type head;
   logic      space, q_empty, q_pop, in_accept;

   assign req_tready = space;
   assign in_accept  = req_tvalid && space;

   sle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .push      (push)
   );

   sle_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .space (space),
      .pop   (q_pop),
      .empty (q_empty),
      .head  (head)
   );

   sle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
